>>> hdl/pcpp_pkg.sv
// pcpp_pkg: shared types and constants for the per-cpu page pool
// no dependencies
package pcpp_pkg;
   localparam int NumCpus    = 8;
   localparam int MaxPages   = 32768;
   localparam int PageBytes  = 4096;
   localparam int CpuW       = 3;
   localparam int IdxW       = 15;
   localparam int LinkW      = 16;
   localparam int CountW     = 16;
   localparam int PageShift  = 12;
   localparam logic [LinkW-1:0]  NilPage  = LinkW'(MaxPages);
   localparam logic [CountW-1:0] CountMax = '1;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOPAGE = 2'd1,
      ST_BADADR = 2'd2,
      ST_NOCPU  = 2'd3
   } status_type;

   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_END   = 2'd1;
   localparam logic [1:0] CSR_MASK  = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  cpu;
      logic [31:0] page_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] alloc_addr;
      logic [15:0] free_count;
   } rsp_type;

   // link memory request from sequencer
   typedef struct packed {
      logic             wr_en;
      logic [IdxW-1:0]  wr_addr;
      logic [LinkW-1:0] wr_data;
      logic             rd_en;
      logic [IdxW-1:0]  rd_addr;
   } lnk_req_type;
endpackage

>>> hdl/per_cpu_page_pool_with_stealing_core.sv
// per_cpu_page_pool_with_stealing_core: top level, sequencer and pool state
// depends on pcpp_pkg and pcpp_link_mem
//
// usage
//   req channel (req_valid / req_stall / req_data) carries one command beat:
//   allocate, free or init for a cpu. each command gives exactly one rsp beat
//   (rsp_valid / rsp_stall / rsp_data) with status, address and free count.
//   csr channel (csr_valid / csr_ready) writes region_start, region_end and
//   cpu_available_mask; write only while the block is idle.
// sequencing
//   free, unused commands and init with no cpu go from decode to the rsp
//   register; an allocate that pops from its own list first waits on the
//   registered read of the link memory.
//   the next req beat is accepted the cycle after the rsp beat leaves.
//   a stealing allocate does a richest-cpu scan, then moves pages one by one
//   with a link read each; it answers no page when nothing can be stolen.
//   init clears the lists, splits n pages over na cpus and pushes them;
//   the split is a repeated subtraction, one step per cycle.
//   one command is in flight at a time; req_stall is high while busy and
//   while a rsp beat waits.
// reset
//   lists empty, counts zero, registers at defaults; link memory needs no clear.
// stall
//   the result sits in the rsp register until taken; the next beat is
//   accepted only after that.
module per_cpu_page_pool_with_stealing_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcpp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcpp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   localparam int LW = pcpp_pkg::LinkW;
   localparam int CW = pcpp_pkg::CountW;
   localparam int IW = pcpp_pkg::IdxW;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_POP_RD, S_POP_WAIT, S_SCAN, S_STEAL_RD, S_STEAL_WAIT,
      S_POP2, S_INIT_CNT, S_INIT_DIV, S_INIT_PUSH, S_RESP
   } state_type;

   state_type state_ff;
   logic [31:0] start_reg_ff, end_reg_ff;
   logic [7:0]  mask_ff;
   logic [LW-1:0] head_ff  [pcpp_pkg::NumCpus];
   logic [CW-1:0] count_ff [pcpp_pkg::NumCpus];
   pcpp_pkg::req_type req_ff;
   pcpp_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [2:0]  scan_ff, src_ff;
   logic [CW-1:0] best_ff, moved_ff;
   logic [LW-1:0] idx_ff;
   // init bookkeeping
   logic [3:0]  na_ff;
   logic [2:0]  avail_k_ff;
   logic [16:0] n_ff, per_ff, rem_ff, p_ff, hi_ff;
   logic [16:0] quo_ff;
   logic [2:0]  cur_cpu_ff;

   pcpp_pkg::lnk_req_type lnk_req;
   logic [LW-1:0] rd_data;

   pcpp_link_mem u_mem (.clock(clock), .lnk_req(lnk_req), .rd_data(rd_data));

   // start rounded up to a page, and page total
   logic [32:0] start_addr;
   logic [32:0] span;
   logic [16:0] page_total;
   assign start_addr = ({1'b0, start_reg_ff} + 33'(pcpp_pkg::PageBytes - 1))
                       & ~33'(pcpp_pkg::PageBytes - 1);
   assign span = {1'b0, end_reg_ff} - start_addr;
   always_comb begin
      if (start_addr[32] || ({1'b0, end_reg_ff} <= start_addr)) begin
         page_total = '0;
      end else if (span[32:pcpp_pkg::PageShift] > 21'(pcpp_pkg::MaxPages)) begin
         page_total = 17'(pcpp_pkg::MaxPages);
      end else begin
         page_total = 17'(span[32:pcpp_pkg::PageShift]);
      end
   end

   // free address check
   logic [32:0] pa_off;
   logic        pa_bad;
   assign pa_off = {1'b0, req_ff.page_addr} - start_addr;
   assign pa_bad = (req_ff.page_addr[pcpp_pkg::PageShift-1:0] != '0)
                   || ({1'b0, req_ff.page_addr} < start_addr)
                   || (req_ff.page_addr >= end_reg_ff)
                   || (pa_off[32:pcpp_pkg::PageShift] >= 21'(pcpp_pkg::MaxPages));

   logic [7:0] avail_mask;
   assign avail_mask = mask_ff[pcpp_pkg::NumCpus-1:0];

   logic [2:0] c;
   assign c = req_ff.cpu;

   logic [CW-1:0] cnt_c;
   assign cnt_c = count_ff[c];

   // next available cpu at or after cur
   logic [2:0] next_avail;
   logic       next_found;
   always_comb begin
      next_avail = '0;
      next_found = 1'b0;
      for (int i = pcpp_pkg::NumCpus - 1; i >= 0; i--) begin
         if (avail_mask[i] && (3'(i) >= cur_cpu_ff)) begin
            next_avail = 3'(i);
            next_found = 1'b1;
         end
      end
   end

   logic [31:0] addr_out;
   assign addr_out = 32'(start_addr)
                     + 32'({idx_ff[IW-1:0], pcpp_pkg::PageShift'(0)});

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      lnk_req = '0;
      unique case (state_ff)
         S_POP_RD: begin
            lnk_req.rd_en   = 1'b1;
            lnk_req.rd_addr = head_ff[c][IW-1:0];
         end
         S_STEAL_RD: begin
            lnk_req.rd_en   = 1'b1;
            lnk_req.rd_addr = head_ff[src_ff][IW-1:0];
         end
         S_STEAL_WAIT: begin
            lnk_req.wr_en   = 1'b1;
            lnk_req.wr_addr = idx_ff[IW-1:0];
            lnk_req.wr_data = head_ff[c];
         end
         S_DECODE: begin
            lnk_req.wr_en   = (req_ff.cmd == pcpp_pkg::CMD_FREE) && !pa_bad;
            lnk_req.wr_addr = pa_off[IW+pcpp_pkg::PageShift-1:pcpp_pkg::PageShift];
            lnk_req.wr_data = head_ff[c];
         end
         S_INIT_PUSH: begin
            lnk_req.wr_en   = (p_ff < hi_ff);
            lnk_req.wr_addr = p_ff[IW-1:0];
            lnk_req.wr_data = head_ff[cur_cpu_ff];
         end
         default: begin
         end
      endcase
   end

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? pcpp_pkg::CountMax : s[CW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         start_reg_ff <= 32'h8000_0000;
         end_reg_ff   <= 32'h8800_0000;
         mask_ff      <= 8'hFF;
         for (int i = 0; i < pcpp_pkg::NumCpus; i++) begin
            head_ff[i]  <= pcpp_pkg::NilPage;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               pcpp_pkg::CSR_START: start_reg_ff <= csr_data;
               pcpp_pkg::CSR_END:   end_reg_ff   <= csr_data;
               pcpp_pkg::CSR_MASK:  mask_ff      <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  req_ff   <= req_data;
                  rsp_ff   <= '0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               unique case (req_ff.cmd)
                  pcpp_pkg::CMD_FREE: begin
                     if (pa_bad) begin
                        rsp_ff.status <= pcpp_pkg::ST_BADADR;
                        rsp_ff.free_count <= cnt_c;
                     end else begin
                        head_ff[c]  <= LW'(pa_off[IW+pcpp_pkg::PageShift-1:pcpp_pkg::PageShift]);
                        count_ff[c] <= sat_add(cnt_c, CW'(1));
                        rsp_ff.free_count <= sat_add(cnt_c, CW'(1));
                     end
                     state_ff <= S_RESP;
                  end
                  pcpp_pkg::CMD_ALLOC: begin
                     if (head_ff[c] >= pcpp_pkg::NilPage) begin
                        scan_ff  <= '0;
                        best_ff  <= '0;
                        src_ff   <= '0;
                        state_ff <= S_SCAN;
                     end else begin
                        state_ff <= S_POP_RD;
                     end
                  end
                  pcpp_pkg::CMD_INIT: begin
                     if (avail_mask == '0) begin
                        rsp_ff.status <= pcpp_pkg::ST_NOCPU;
                        rsp_ff.free_count <= cnt_c;
                        state_ff <= S_RESP;
                     end else begin
                        na_ff    <= 4'($countones(avail_mask));
                        state_ff <= S_INIT_CNT;
                     end
                  end
                  default: begin
                     rsp_ff.free_count <= cnt_c;
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_POP_RD: begin
               idx_ff   <= head_ff[c];
               state_ff <= S_POP_WAIT;
            end
            S_POP_WAIT: begin
               head_ff[c] <= (rd_data > pcpp_pkg::NilPage) ? pcpp_pkg::NilPage : rd_data;
               if (cnt_c > 0) begin
                  count_ff[c] <= cnt_c - 1'b1;
                  rsp_ff.free_count <= cnt_c - 1'b1;
               end else begin
                  rsp_ff.free_count <= cnt_c;
               end
               rsp_ff.alloc_addr <= addr_out;
               state_ff <= S_RESP;
            end
            S_SCAN: begin
               if (scan_ff == '0 || count_ff[scan_ff] > best_ff) begin
                  best_ff <= count_ff[scan_ff];
                  src_ff  <= scan_ff;
               end
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == 3'(pcpp_pkg::NumCpus - 1)) begin
                  state_ff <= S_STEAL_RD;
                  moved_ff <= '0;
               end
            end
            S_STEAL_RD: begin
               if (moved_ff == '0 && (src_ff == c || best_ff == '0)) begin
                  rsp_ff.status <= pcpp_pkg::ST_NOPAGE;
                  rsp_ff.free_count <= cnt_c;
                  state_ff <= S_RESP;
               end else begin
                  if (moved_ff >= (best_ff >> 1) || head_ff[src_ff] >= pcpp_pkg::NilPage) begin
                     count_ff[src_ff] <= count_ff[src_ff] - moved_ff;
                     count_ff[c] <= sat_add(cnt_c, moved_ff);
                     state_ff <= S_POP2;
                  end else begin
                     idx_ff   <= head_ff[src_ff];
                     state_ff <= S_STEAL_WAIT;
                  end
               end
            end
            S_STEAL_WAIT: begin
               head_ff[src_ff] <= (rd_data > pcpp_pkg::NilPage) ? pcpp_pkg::NilPage : rd_data;
               head_ff[c]      <= idx_ff;
               moved_ff        <= moved_ff + 1'b1;
               state_ff        <= S_STEAL_RD;
            end
            S_POP2: begin
               if (head_ff[c] >= pcpp_pkg::NilPage) begin
                  rsp_ff.status <= pcpp_pkg::ST_NOPAGE;
                  rsp_ff.free_count <= cnt_c;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_POP_RD;
               end
            end
            S_INIT_CNT: begin
               for (int i = 0; i < pcpp_pkg::NumCpus; i++) begin
                  head_ff[i]  <= pcpp_pkg::NilPage;
                  count_ff[i] <= '0;
               end
               n_ff     <= page_total;
               rem_ff   <= page_total;
               quo_ff   <= '0;
               state_ff <= S_INIT_DIV;
            end
            S_INIT_DIV: begin
               // repeated subtraction, one step per cycle; the quotient is at most 32768 / na
               if (rem_ff >= 17'(na_ff)) begin
                  rem_ff <= rem_ff - 17'(na_ff);
                  quo_ff <= quo_ff + 1'b1;
               end else begin
                  per_ff     <= quo_ff;
                  avail_k_ff <= '0;
                  cur_cpu_ff <= '0;
                  p_ff       <= '0;
                  hi_ff      <= (na_ff == 4'd1) ? n_ff : quo_ff;
                  state_ff   <= S_INIT_PUSH;
               end
            end
            S_INIT_PUSH: begin
               if (cur_cpu_ff != next_avail) begin
                  cur_cpu_ff <= next_avail;
               end else if (p_ff < hi_ff) begin
                  head_ff[cur_cpu_ff] <= LW'(p_ff);
                  count_ff[cur_cpu_ff] <= sat_add(count_ff[cur_cpu_ff], CW'(1));
                  p_ff <= p_ff + 1'b1;
               end else if (4'(avail_k_ff) + 4'd1 >= na_ff || !next_found) begin
                  rsp_ff.free_count <= (c == cur_cpu_ff) ? count_ff[cur_cpu_ff] : count_ff[c];
                  state_ff <= S_RESP;
               end else begin
                  avail_k_ff <= avail_k_ff + 1'b1;
                  cur_cpu_ff <= cur_cpu_ff + 1'b1;
                  hi_ff <= (4'(avail_k_ff) + 4'd2 == na_ff) ? n_ff : hi_ff + per_ff;
               end
            end
            S_RESP: begin
               // rsp register is always empty here, the req side waits for it
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> hdl/pcpp_link_mem.sv
// pcpp_link_mem: next-link store, one write and one registered read per cycle
// depends on pcpp_pkg
module pcpp_link_mem (
   input  logic                        clock,
   input  pcpp_pkg::lnk_req_type       lnk_req,
   output logic [pcpp_pkg::LinkW-1:0]  rd_data
);
   logic [pcpp_pkg::LinkW-1:0] mem_ff [pcpp_pkg::MaxPages];

   always_ff @(posedge clock) begin
      if (lnk_req.wr_en) begin
         mem_ff[lnk_req.wr_addr] <= lnk_req.wr_data;
      end
      if (lnk_req.rd_en) begin
         rd_data <= mem_ff[lnk_req.rd_addr];
      end
   end
endmodule
